FILE: hw/rtl/pixel_realism_post_filter_unit_macros.svh
// Assertion macros shared by the pixel realism post filter RTL.
`ifndef PIXEL_REALISM_POST_FILTER_UNIT_MACROS_SVH
`define PIXEL_REALISM_POST_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PRPF_ASSERT_IMPLIES(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("prpf assertion failed");
`define PRPF_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("prpf assertion failed");
`else
`define PRPF_ASSERT_IMPLIES(name, pre, post)
`define PRPF_ASSERT_NEXT(name, pre, post)
`endif
`endif

FILE: hw/rtl/prpf_pkg.sv
// Shared types and constants of the pixel realism post filter.
package prpf_pkg;
	localparam int MAX_WIDTH = 1024;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int FW_W = 11;
	localparam int RW = 12;
	localparam int CFG_W = 12;
	localparam int QDEPTH = 8;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	typedef logic [23:0] pixel_t;
	typedef logic [0:0] cfg_idx_t;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam cfg_idx_t REG_FRAME_WIDTH = 1'b0;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] WIDTH_RESET = 11'd960;
	localparam logic [RW-1:0] HEIGHT_RESET = 12'd400;

	localparam logic [15:0] LUMA_R = 16'd77;
	localparam logic [15:0] LUMA_G = 16'd150;
	localparam logic [15:0] LUMA_B = 16'd29;
	localparam logic [10:0] EDGE_FLOOR = 11'd80;
	localparam logic [3:0] EDGE_CAP = 4'd12;
	localparam logic signed [19:0] SAT_GAIN = 20'sd140;
	localparam logic [7:0] LUM_WARM = 8'd100;
	localparam logic [7:0] LUM_COOL = 8'd60;

	typedef struct packed {
		pixel_t center;
		pixel_t up;
		pixel_t down;
		pixel_t left;
		pixel_t right;
		logic last;
		logic done;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic room;
		logic not_empty;
	} queue_stat_t;

	typedef struct packed {
		logic flush_pending;
	} front_stat_t;
endpackage

FILE: hw/rtl/prpf_stream_if.sv
// Stream interfaces for the input and result channels.
interface prpf_in_if;
	logic valid;
	logic ready;
	logic operation;
	prpf_pkg::pixel_t pixel_in;
	modport source(output valid, output operation, output pixel_in, input ready);
	modport sink(input valid, input operation, input pixel_in, output ready);
endinterface

interface prpf_out_if;
	logic valid;
	logic ready;
	prpf_pkg::pixel_t pixel_out;
	logic last_of_run;
	logic frame_done;
	modport source(output valid, output pixel_out, output last_of_run, output frame_done,
		input ready);
	modport sink(input valid, input pixel_out, input last_of_run, input frame_done,
		output ready);
endinterface

FILE: hw/rtl/prpf_front.sv
// Front end: input accept, raster counters, line stores and neighborhood jobs.
module prpf_front (
	input logic clk,
	input logic arst_n,
	prpf_in_if.sink in_ch,
	input logic cfg_we,
	input prpf_pkg::cfg_idx_t cfg_index,
	input logic [prpf_pkg::CFG_W-1:0] cfg_wdata,
	input prpf_pkg::queue_stat_t q_stat,
	output prpf_pkg::job_push_t job_push,
	output prpf_pkg::front_stat_t f_stat
);
	import prpf_pkg::*;

	localparam int NBANK = 3;

	logic [FW_W-1:0] fw_q;
	logic [RW-1:0] fh_q;
	logic [XW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0] cur_q;
	logic flush_pend_q;
	logic [XW-1:0] fx_q;
	pixel_t left_q;

	logic [FW_W-1:0] w_eff;
	logic [XW-1:0] wlast, x, ix, xp;
	logic [RW-1:0] h_eff;
	logic rows_in, acc, is_pixel, px_store, issue_px, issue_fl1, issue, ix_last;
	logic [1:0] above_idx, below_idx, wsel;

	logic v_s1, first_s1, flush_s1, last_s1, done_s1, x0_s1;
	logic [1:0] cur_s1, abv_s1;
	pixel_t pix_s1;
	pixel_t rd_a_s1 [NBANK];
	pixel_t rd_b_s1 [NBANK];
	pixel_t center;

	always_comb begin
		if (fw_q == '0) begin
			w_eff = FW_W'(1);
		end else if (fw_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = fw_q;
		end
	end

	assign wlast = XW'(w_eff - FW_W'(1));
	assign h_eff = (fh_q == '0) ? RW'(1) : fh_q;
	assign x = (col_q > wlast) ? wlast : col_q;
	assign rows_in = row_q >= h_eff;
	assign above_idx = (cur_q == 2'd0) ? 2'd2 : cur_q - 2'd1;
	assign below_idx = (cur_q == 2'd2) ? 2'd0 : cur_q + 2'd1;

	assign in_ch.ready = !flush_pend_q && q_stat.room;
	assign acc = in_ch.valid && in_ch.ready;
	assign is_pixel = in_ch.operation == OP_PIXEL;
	assign px_store = acc && is_pixel && !rows_in;
	assign issue_px = px_store && (row_q != '0);
	assign issue_fl1 = acc && (in_ch.operation == OP_FLUSH) && rows_in;
	assign issue = issue_px || issue_fl1 || flush_pend_q;

	assign ix = flush_pend_q ? fx_q : x;
	assign ix_last = ix >= wlast;
	assign xp = ix_last ? ix : ix + XW'(1);
	assign wsel = (row_q == '0) ? cur_q : below_idx;

	// Three row stores rotate between the above, current and below roles.
	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		pixel_t mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (px_store && wsel == 2'(b)) begin
				mem[x] <= in_ch.pixel_in;
			end
			rd_a_s1[b] <= mem[ix];
			rd_b_s1[b] <= mem[xp];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= WIDTH_RESET;
			fh_q <= HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
			cur_q <= '0;
			flush_pend_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: fw_q <= cfg_wdata[FW_W-1:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_wdata[RW-1:0];
					default: ;
				endcase
			end
			if (px_store) begin
				if (x >= wlast) begin
					col_q <= '0;
					if (row_q != '0) begin
						cur_q <= below_idx;
					end
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= x + XW'(1);
				end
			end
			if (issue_fl1) begin
				if (ix_last) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= x + XW'(1);
					flush_pend_q <= 1'b1;
				end
			end
			if (flush_pend_q) begin
				flush_pend_q <= 1'b0;
				if (ix_last) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= fx_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fx_q <= x + XW'(1);
		first_s1 <= issue_px ? (row_q == RW'(1)) : (h_eff == RW'(1));
		flush_s1 <= !issue_px;
		last_s1 <= issue_px || flush_pend_q || ix_last;
		done_s1 <= !issue_px && ix_last;
		x0_s1 <= ix == '0;
		cur_s1 <= cur_q;
		abv_s1 <= above_idx;
		pix_s1 <= in_ch.pixel_in;
		if (v_s1) begin
			left_q <= center;
		end
	end

	assign center = rd_a_s1[cur_s1];

	always_comb begin
		job_push.push = v_s1;
		job_push.job.center = center;
		job_push.job.up = first_s1 ? center : rd_a_s1[abv_s1];
		job_push.job.down = flush_s1 ? center : pix_s1;
		job_push.job.left = x0_s1 ? center : left_q;
		job_push.job.right = rd_b_s1[cur_s1];
		job_push.job.last = last_s1;
		job_push.job.done = done_s1;
	end

	assign f_stat.flush_pending = flush_pend_q;
endmodule

FILE: hw/rtl/prpf_queue.sv
// Short job queue between the front end and the filter pipeline.
module prpf_queue (
	input logic clk,
	input logic arst_n,
	input prpf_pkg::job_push_t job_push,
	input logic pop,
	output prpf_pkg::job_t head,
	output prpf_pkg::queue_stat_t q_stat
);
	import prpf_pkg::*;

	job_t slot_q [QDEPTH];
	logic [QAW-1:0] rd_q, wr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else begin
			if (job_push.push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			count_q <= count_q + QCW'(job_push.push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (job_push.push) begin
			slot_q[wr_q] <= job_push.job;
		end
	end

	assign head = slot_q[rd_q];
	// Three free slots cover the job still in the front end's read stage and
	// the second job of a flush word, which issues without a room check.
	assign q_stat.room = count_q <= QCW'(QDEPTH - 3);
	assign q_stat.not_empty = count_q != '0;
	assign q_stat.count = count_q;
endmodule

FILE: hw/rtl/prpf_back.sv
// Filter pipeline: contrast, edge darkening, saturation, grading, de-banding.
module prpf_back (
	input logic clk,
	input logic arst_n,
	input prpf_pkg::job_t head,
	input prpf_pkg::queue_stat_t q_stat,
	output logic pop,
	prpf_out_if.source out_ch
);
	import prpf_pkg::*;

	function automatic logic [7:0] luma(input pixel_t p);
		logic [15:0] s;
		s = LUMA_R * 16'(p[23:16]) + LUMA_G * 16'(p[15:8]) + LUMA_B * 16'(p[7:0]);
		return s[15:8];
	endfunction

	function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic signed [10:0] shade(input logic [7:0] c,
		input logic signed [10:0] cd, input logic [3:0] ao);
		return 11'(signed'({3'b000, c})) + cd - signed'({7'b0, ao});
	endfunction

	function automatic logic signed [11:0] sat(input logic signed [10:0] v,
		input logic signed [10:0] grey);
		logic signed [11:0] d;
		logic signed [19:0] p;
		d = 12'(v) - 12'(grey);
		p = 20'(d) * SAT_GAIN;
		return 12'(grey) + 12'(p >>> 7);
	endfunction

	// A channel 3 to 5 away from both horizontal neighbors is blended toward them.
	function automatic logic signed [11:0] deband(input logic signed [11:0] v,
		input logic [7:0] l, input logic [7:0] r);
		logic signed [12:0] dl, dr;
		logic [12:0] adl, adr;
		logic signed [13:0] t;
		logic [13:0] mag;
		logic [28:0] prod;
		logic signed [11:0] qs;
		dl = 13'(v) - signed'({5'b0, l});
		dr = 13'(v) - signed'({5'b0, r});
		adl = (dl < 0) ? unsigned'(-dl) : unsigned'(dl);
		adr = (dr < 0) ? unsigned'(-dr) : unsigned'(dr);
		t = (14'(v) <<< 1) + 14'(v) + signed'({6'b0, l}) + signed'({6'b0, r});
		mag = (t < 0) ? unsigned'(-t) : unsigned'(t);
		prod = 29'(mag) * 29'd13108;
		qs = signed'({1'b0, prod[26:16]});
		if ((adl inside {[13'd3:13'd5]}) && (adr inside {[13'd3:13'd5]})) begin
			return (t < 0) ? -qs : qs;
		end
		return v;
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [11:0] v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 12'sd255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign pop = en && q_stat.not_empty;

	// Stage 1: luminances and edge strength.
	logic [7:0] lum_c;
	logic [9:0] nsum;
	logic [10:0] edge_c;
	pixel_t nb [4];
	always_comb begin
		nb[0] = head.up;
		nb[1] = head.down;
		nb[2] = head.left;
		nb[3] = head.right;
		lum_c = luma(head.center);
		nsum = '0;
		edge_c = '0;
		for (int k = 0; k < 4; k++) begin
			nsum = nsum + 10'(luma(nb[k]));
			edge_c = edge_c + 11'(absd(head.center[23:16], nb[k][23:16]))
				+ 11'(absd(head.center[15:8], nb[k][15:8]));
		end
	end

	logic v_s1, last_s1, done_s1;
	pixel_t c_s1, lf_s1, rt_s1;
	logic [7:0] lum_s1, avg_s1;
	logic [10:0] edge_s1;

	// Stage 2: contrast boost and capped edge darkening.
	logic signed [12:0] dx, d12;
	logic signed [10:0] cd;
	logic [10:0] eo;
	logic [3:0] ao;
	always_comb begin
		dx = 13'(signed'({1'b0, lum_s1})) - 13'(signed'({1'b0, avg_s1}));
		d12 = (dx <<< 3) + (dx <<< 2);
		cd = 11'(d12 >>> 7);
		eo = (edge_s1 - EDGE_FLOOR) >> 3;
		if (edge_s1 <= EDGE_FLOOR) begin
			ao = '0;
		end else if (eo > 11'(EDGE_CAP)) begin
			ao = EDGE_CAP;
		end else begin
			ao = eo[3:0];
		end
	end

	logic v_s2, last_s2, done_s2;
	logic signed [10:0] r_s2, g_s2, b_s2;
	logic [7:0] lum_s2;
	pixel_t lf_s2, rt_s2;

	// Stage 3: grey level, sum divided by three truncating toward zero.
	logic signed [12:0] sum3;
	logic [12:0] mag3;
	logic [29:0] prod3;
	logic signed [10:0] gq, grey;
	always_comb begin
		sum3 = 13'(r_s2) + 13'(g_s2) + 13'(b_s2);
		mag3 = (sum3 < 0) ? unsigned'(-sum3) : unsigned'(sum3);
		prod3 = 30'(mag3) * 30'd43691;
		gq = signed'({1'b0, prod3[26:17]});
		grey = (sum3 < 0) ? -gq : gq;
	end

	logic v_s3, last_s3, done_s3;
	logic signed [10:0] r_s3, g_s3, b_s3, grey_s3;
	logic [7:0] lum_s3;
	pixel_t lf_s3, rt_s3;

	// Stage 4: saturation and warm or cool grading.
	logic signed [11:0] r4n, g4n, b4n;
	logic [7:0] wd, cdiff;
	logic [3:0] wm, cl;
	always_comb begin
		r4n = sat(r_s3, grey_s3);
		g4n = sat(g_s3, grey_s3);
		b4n = sat(b_s3, grey_s3);
		wd = (lum_s3 - LUM_WARM) >> 4;
		cdiff = (LUM_COOL - lum_s3) >> 4;
		wm = wd[3:0];
		cl = cdiff[3:0];
		if (lum_s3 > LUM_WARM) begin
			r4n = r4n + signed'({8'b0, wm});
			g4n = g4n + signed'({9'b0, wm[3:1]});
		end
		if (lum_s3 < LUM_COOL) begin
			b4n = b4n + signed'({8'b0, cl});
			r4n = r4n - signed'({9'b0, cl[3:1]});
		end
	end

	logic v_s4, last_s4, done_s4;
	logic signed [11:0] r_s4, g_s4, b_s4;
	pixel_t lf_s4, rt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_ch.valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= head.center;
			lf_s1 <= head.left;
			rt_s1 <= head.right;
			lum_s1 <= lum_c;
			avg_s1 <= nsum[9:2];
			edge_s1 <= edge_c;
			last_s1 <= head.last;
			done_s1 <= head.done;

			r_s2 <= shade(c_s1[23:16], cd, ao);
			g_s2 <= shade(c_s1[15:8], cd, ao);
			b_s2 <= shade(c_s1[7:0], cd, ao);
			lum_s2 <= lum_s1;
			lf_s2 <= lf_s1;
			rt_s2 <= rt_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;

			r_s3 <= r_s2;
			g_s3 <= g_s2;
			b_s3 <= b_s2;
			grey_s3 <= grey;
			lum_s3 <= lum_s2;
			lf_s3 <= lf_s2;
			rt_s3 <= rt_s2;
			last_s3 <= last_s2;
			done_s3 <= done_s2;

			r_s4 <= r4n;
			g_s4 <= g4n;
			b_s4 <= b4n;
			lf_s4 <= lf_s3;
			rt_s4 <= rt_s3;
			last_s4 <= last_s3;
			done_s4 <= done_s3;

			out_ch.pixel_out <= {clamp8(deband(r_s4, lf_s4[23:16], rt_s4[23:16])),
				clamp8(deband(g_s4, lf_s4[15:8], rt_s4[15:8])),
				clamp8(deband(b_s4, lf_s4[7:0], rt_s4[7:0]))};
			out_ch.last_of_run <= last_s4;
			out_ch.frame_done <= done_s4;
		end
	end
endmodule

FILE: hw/rtl/pixel_realism_post_filter_unit.sv
// A result passes the front end's read stage, the job queue and the filter pipeline registers.
// One input word per cycle while the queue has room; a flush word with two results holds input.
// The rate is set by the line stores, which give the center, right and above pixels in one read.
// Reset clears counters, queue and pipeline valids and loads width 960 and height 400.
// The line stores are not cleared; each entry is written before it is read.
`include "pixel_realism_post_filter_unit_macros.svh"
module pixel_realism_post_filter_unit (
	input logic clk,
	input logic arst_n,
	prpf_in_if.sink in_ch,
	prpf_out_if.source out_ch,
	input logic cfg_we,
	input prpf_pkg::cfg_idx_t cfg_index,
	input logic [prpf_pkg::CFG_W-1:0] cfg_wdata
);
	import prpf_pkg::*;

	job_push_t job_push;
	job_t head;
	queue_stat_t q_stat;
	front_stat_t f_stat;
	logic pop;

	prpf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.q_stat(q_stat),
		.job_push(job_push),
		.f_stat(f_stat)
	);

	prpf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.job_push(job_push),
		.pop(pop),
		.head(head),
		.q_stat(q_stat)
	);

	prpf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_stat(q_stat),
		.pop(pop),
		.out_ch(out_ch)
	);

	`PRPF_ASSERT_IMPLIES(a_push_fits, job_push.push, q_stat.count < QCW'(QDEPTH))
	`PRPF_ASSERT_IMPLIES(a_done_ends_run, out_ch.valid && out_ch.frame_done, out_ch.last_of_run)
	`PRPF_ASSERT_NEXT(a_flush_second_once, f_stat.flush_pending, !f_stat.flush_pending)
endmodule
